>>> hdl/bfdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdp_pkg
// Shared types, register indexes and floating-point helper functions for the
// bf16 dot product accumulator: bf16 x bf16 multiply rounded to fp32, and an
// fp32 add with round to nearest even and subnormals kept.
// ----------------------------------------------------------------------------
package bfdp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ACC_MODE = 2'd0;
  localparam logic [1:0] CFG_BIAS_EN  = 2'd1;
  localparam logic [1:0] CFG_OUT_BF16 = 2'd2;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // Output-side settings handed to the output stage.
  typedef struct packed {
    logic bias_enable;
    logic output_bf16;
  } out_cfg_t;

  // Leading zero count of a 27-bit word; 27 for a zero word.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    logic       hit;
    cnt = 5'd27;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit && v[i]) begin
        cnt = 5'(26 - i);
        hit = 1'b1;
      end
    end
    return cnt;
  endfunction

  // Round a normalized 27-bit significand (24 bits plus guard, round, sticky)
  // to nearest even and pack it. A clear leading bit means a subnormal, e = 1.
  function automatic logic [31:0] round_pack(input logic       sgn,
                                             input logic [9:0] e,
                                             input logic [26:0] n);
    logic        up;
    logic [24:0] m;
    logic [9:0]  ef;
    logic [22:0] frac;
    up = n[2] & (n[1] | n[0] | n[3]);
    m  = {1'b0, n[26:3]} + {24'd0, up};
    if (m[24]) begin
      ef   = e + 10'd1;
      frac = m[23:1];
    end else begin
      ef   = m[23] ? e : 10'd0;
      frac = m[22:0];
    end
    if (ef >= 10'd255) begin
      return {sgn, 8'hFF, 23'd0};
    end
    return {sgn, ef[7:0], frac};
  endfunction

  // fp32 addition.
  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a;
    logic [31:0] b;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic [7:0]  exa;
    logic [7:0]  exb;
    logic [7:0]  d;
    logic [26:0] a27;
    logic [26:0] b27;
    logic [53:0] ext;
    logic [26:0] bsh;
    logic [27:0] s;
    logic [26:0] n;
    logic [9:0]  e;
    logic [4:0]  lz;
    logic [4:0]  sh;
    if (y[30:0] > x[30:0]) begin
      a = y;
      b = x;
    end else begin
      a = x;
      b = y;
    end
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    exa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    exb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    d   = exa - exb;
    a27 = {(a[30:23] != 8'd0), a[22:0], 3'b000};
    b27 = {(b[30:23] != 8'd0), b[22:0], 3'b000};
    // Align the smaller operand and fold the bits shifted out into a sticky.
    if (d >= 8'd27) begin
      bsh = {26'd0, (b27 != 27'd0)};
    end else begin
      ext = {b27, 27'd0} >> d;
      bsh = ext[53:27] | {26'd0, (ext[26:0] != 27'd0)};
    end
    if (a[31] == b[31]) begin
      s = {1'b0, a27} + {1'b0, bsh};
    end else begin
      s = {1'b0, a27} - {1'b0, bsh};
    end
    // Normalize: one step right on carry out, otherwise left down to e = 1.
    if (s[27]) begin
      n = s[27:1] | {26'd0, s[0]};
      e = {2'b00, exa} + 10'd1;
    end else begin
      lz = lzc27(s[26:0]);
      sh = ({3'b000, lz} < exa) ? lz : 5'(exa - 8'd1);
      n  = s[26:0] << sh;
      e  = {2'b00, exa} - {5'd0, sh};
    end
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      return QNAN;
    end
    if (a_inf) begin
      return a;
    end
    if (s == 28'd0) begin
      return {a[31] & b[31], 31'd0};
    end
    return round_pack(a[31], e, n);
  endfunction

  // bf16 x bf16 multiply, rounded once to fp32.
  function automatic logic [31:0] bf16_mul(input logic [15:0] x, input logic [15:0] y);
    logic               sgn;
    logic               x_nan;
    logic               y_nan;
    logic               x_inf;
    logic               y_inf;
    logic               x_zero;
    logic               y_zero;
    logic [7:0]         ma;
    logic [7:0]         mb;
    logic [15:0]        p;
    logic [26:0]        nin;
    logic signed [10:0] e_raw;
    logic signed [10:0] e_cand;
    logic signed [10:0] rs;
    logic [4:0]         lz;
    logic [53:0]        ext;
    logic [26:0]        n;
    logic [9:0]         e;
    sgn    = x[15] ^ y[15];
    x_nan  = (x[14:7] == 8'hFF) && (x[6:0] != 7'd0);
    y_nan  = (y[14:7] == 8'hFF) && (y[6:0] != 7'd0);
    x_inf  = (x[14:7] == 8'hFF) && (x[6:0] == 7'd0);
    y_inf  = (y[14:7] == 8'hFF) && (y[6:0] == 7'd0);
    x_zero = (x[14:0] == 15'd0);
    y_zero = (y[14:0] == 15'd0);
    ma     = {(x[14:7] != 8'd0), x[6:0]};
    mb     = {(y[14:7] != 8'd0), y[6:0]};
    p      = ma * mb;
    nin    = {p, 11'd0};
    e_raw  = $signed({3'b000, ((x[14:7] == 8'd0) ? 8'd1 : x[14:7])})
           + $signed({3'b000, ((y[14:7] == 8'd0) ? 8'd1 : y[14:7])})
           - 11'sd126;
    lz     = lzc27(nin);
    e_cand = e_raw - $signed({6'd0, lz});
    // Normal results shift left; tiny ones clamp at e = 1 or shift right.
    if (e_cand >= 11'sd1) begin
      n = nin << lz;
      e = 10'(e_cand);
    end else if (e_raw >= 11'sd1) begin
      n = nin << 5'(e_raw - 11'sd1);
      e = 10'd1;
    end else begin
      rs = 11'sd1 - e_raw;
      e  = 10'd1;
      if (rs > 11'sd27) begin
        n = {26'd0, (nin != 27'd0)};
      end else begin
        ext = {nin, 27'd0} >> 5'(rs);
        n   = ext[53:27] | {26'd0, (ext[26:0] != 27'd0)};
      end
    end
    if (x_nan || y_nan || (x_inf && y_zero) || (y_inf && x_zero)) begin
      return QNAN;
    end
    if (x_inf || y_inf) begin
      return {sgn, 8'hFF, 23'd0};
    end
    if (x_zero || y_zero) begin
      return {sgn, 31'd0};
    end
    return round_pack(sgn, e, n);
  endfunction

endpackage

>>> hdl/bfdp_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdp_out
// Output stage: holds a finished sum, adds the optional bias, applies the
// optional bf16 rounding and presents the result through a result register.
// ----------------------------------------------------------------------------
module bfdp_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [31:0]         sum_i,
  input  logic [31:0]         bias_i,
  input  bfdp_pkg::out_cfg_t  cfg_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         result_value_o
);
  import bfdp_pkg::*;

  logic        fin_valid_q;
  logic [31:0] fin_sum_q;
  logic [31:0] fin_bias_q;
  logic        res_valid_q;
  logic [31:0] res_q;
  logic        fin_adv;
  logic [31:0] biased;
  logic [31:0] rounded;
  logic [31:0] res_d;

  // The held sum moves on when the result register is empty or being taken.
  assign fin_adv = fin_valid_q && (!res_valid_q || !out_stall_i);
  assign free_o  = !fin_valid_q || fin_adv;

  // Bias add and bf16 rounding.
  always_comb begin
    biased  = cfg_i.bias_enable ? fp_add(fin_sum_q, fin_bias_q) : fin_sum_q;
    rounded = biased + 32'h0000_8000;
    res_d   = cfg_i.output_bf16 ? {16'd0, rounded[31:16]} : biased;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        fin_valid_q <= 1'b1;
      end else if (fin_adv) begin
        fin_valid_q <= 1'b0;
      end
      if (fin_adv) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fin_sum_q  <= sum_i;
      fin_bias_q <= bias_i;
    end
    if (fin_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign result_value_o = res_q;

endmodule

>>> hdl/bf16_dot_product_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_dot_product_accumulator
// bf16 dot product with fp32 accumulation: two products per item are added
// into one fp32 accumulator, with optional prior sum, bias and bf16 output.
// ----------------------------------------------------------------------------
// An item is accepted when idle or while the previous one finishes its odd add,
// which for a last item waits for a free output stage; the single fp32 adder
// on the accumulator loop is used once for the even and once for the odd product.
// Reset clears the accumulator to +0.0, all settings to zero and empties
// every stage.
module bf16_dot_product_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [0:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] a_even_i,
  input  logic [15:0] a_odd_i,
  input  logic [15:0] b_even_i,
  input  logic [15:0] b_odd_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [31:0] prior_sum_i,
  input  logic [31:0] bias_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o
);
  import bfdp_pkg::*;

  logic        acc_mode_q;
  out_cfg_t    ocfg_q;
  logic        wk_busy_q;
  logic        wk_phase_q;
  logic        wk_first_q;
  logic        wk_last_q;
  logic [31:0] prod_even_q;
  logic [31:0] prod_odd_q;
  logic [31:0] prior_q;
  logic [31:0] bias_q;
  logic [31:0] acc_q;
  logic [31:0] acc_d;
  logic [31:0] acc_base;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        fin_free;
  logic        wk_done;
  logic        accept;
  logic        acc_we;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_mode_q <= 1'b0;
      ocfg_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACC_MODE: acc_mode_q         <= cfg_wdata_i[0];
        CFG_BIAS_EN:  ocfg_q.bias_enable <= cfg_wdata_i[0];
        CFG_OUT_BF16: ocfg_q.output_bf16 <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  // Handshake: an item enters when idle or while the previous one finishes its odd add.
  assign wk_done    = wk_busy_q && wk_phase_q && (!wk_last_q || fin_free);
  assign accept     = in_valid_i && (!wk_busy_q || wk_done);
  assign in_stall_o = !(!wk_busy_q || wk_done);

  // Accumulator add: even product in phase zero, odd product in phase one.
  always_comb begin
    acc_base = wk_first_q ? (acc_mode_q ? prior_q : 32'd0) : acc_q;
    add_a    = wk_phase_q ? prod_odd_q : prod_even_q;
    add_b    = wk_phase_q ? acc_q : acc_base;
    acc_d    = fp_add(add_a, add_b);
    acc_we   = wk_busy_q && (!wk_phase_q || wk_done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk_busy_q  <= 1'b0;
      wk_phase_q <= 1'b0;
      acc_q      <= 32'd0;
    end else begin
      if (acc_we) begin
        acc_q <= acc_d;
      end
      if (wk_busy_q && !wk_phase_q) begin
        wk_phase_q <= 1'b1;
      end else if (!wk_busy_q || wk_done) begin
        wk_busy_q  <= accept;
        wk_phase_q <= 1'b0;
      end
    end
  end

  // Input register with the two products formed on the way in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_even_q <= bf16_mul(a_even_i, b_even_i);
      prod_odd_q  <= bf16_mul(a_odd_i, b_odd_i);
      wk_first_q  <= first_i;
      wk_last_q   <= last_i;
      prior_q     <= prior_sum_i;
      bias_q      <= bias_i;
    end
  end

  bfdp_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (wk_done && wk_last_q),
    .sum_i          (acc_d),
    .bias_i         (bias_q),
    .cfg_i          (ocfg_q),
    .free_o         (fin_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o)
  );

endmodule

>>> tb/sv/bf16_dot_product_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_dot_product_accumulator_tb
// Self-checking testbench for the bf16 dot product accumulator. A scoreboard
// keeps its own fp32 accumulator and settings, and computes each expected
// result in double precision with explicit rounding to fp32. Directed items
// cover the special values, then random runs of items go through every
// setting under several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module bf16_dot_product_accumulator_tb;
  import bfdp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 240;

  typedef struct {
    logic [15:0] a_even;
    logic [15:0] a_odd;
    logic [15:0] b_even;
    logic [15:0] b_odd;
    logic        first;
    logic        last;
    logic [31:0] prior_sum;
    logic [31:0] bias;
  } item_t;

  // Scoreboard: predicts the results of accepted items and checks them in order.
  class dot_scoreboard;
    logic        acc_mode;
    logic        bias_en;
    logic        out_bf16;
    logic [31:0] acc_bits;
    logic [31:0] expected_q[$];
    int          errors;

    function new();
      acc_mode = 1'b0;
      bias_en  = 1'b0;
      out_bf16 = 1'b0;
      acc_bits = 32'd0;
      errors   = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      errors++;
    endfunction

    // Widen fp32 bits to a double, subnormals included.
    static function real f32_to_real(logic [31:0] x);
      logic [63:0] d;
      logic [22:0] m;
      int          p;
      int          e;
      if (x[30:23] == 8'hFF) begin
        d = (x[22:0] != 23'd0) ? 64'h7FF8_0000_0000_0000 : {x[31], 11'h7FF, 52'd0};
      end else if (x[30:23] == 8'd0) begin
        if (x[22:0] == 23'd0) begin
          d = {x[31], 63'd0};
        end else begin
          p = 22;
          while (!x[p]) p--;
          m = x[22:0] << (23 - p);
          e = p - 149 + 1023;
          d = {x[31], e[10:0], m, 29'd0};
        end
      end else begin
        e = int'(x[30:23]) - 127 + 1023;
        d = {x[31], e[10:0], x[22:0], 29'd0};
      end
      return $bitstoreal(d);
    endfunction

    // Round a double to fp32 bits, nearest even, subnormals kept, one quiet NaN.
    static function logic [31:0] real_to_f32(real r);
      logic [63:0]     d;
      longint unsigned sig;
      longint unsigned kept;
      longint unsigned rem;
      longint unsigned half;
      longint unsigned mag;
      int              e;
      int              sh;
      int              base;
      d = $realtobits(r);
      e = int'(d[62:52]);
      if (e == 2047) begin
        return (d[51:0] != 52'd0) ? QNAN : {d[63], 8'hFF, 23'd0};
      end
      if (e == 0) begin
        return {d[63], 31'd0};
      end
      e = e - 1023;
      if (e < -126) begin
        sh   = 29 + (-126 - e);
        base = 0;
      end else begin
        sh   = 29;
        base = e + 126;
      end
      if (sh > 54) begin
        return {d[63], 31'd0};
      end
      sig  = {11'd0, 1'b1, d[51:0]};
      kept = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
      mag = (longint'(base) << 23) + kept;
      if (mag >= 64'h7F80_0000) begin
        return {d[63], 8'hFF, 23'd0};
      end
      return {d[63], mag[30:0]};
    endfunction

    static function logic [31:0] mul_bf16(logic [15:0] x, logic [15:0] y);
      return real_to_f32(f32_to_real({x, 16'd0}) * f32_to_real({y, 16'd0}));
    endfunction

    static function logic [31:0] add_f32(logic [31:0] x, logic [31:0] y);
      return real_to_f32(f32_to_real(x) + f32_to_real(y));
    endfunction

    function void note_item(item_t it);
      logic [31:0] sum;
      if (it.first) acc_bits = acc_mode ? it.prior_sum : 32'd0;
      acc_bits = add_f32(mul_bf16(it.a_even, it.b_even), acc_bits);
      acc_bits = add_f32(mul_bf16(it.a_odd, it.b_odd), acc_bits);
      if (it.last) begin
        sum = acc_bits;
        if (bias_en) sum = add_f32(sum, it.bias);
        if (out_bf16) sum = (sum + 32'h8000) >> 16;
        expected_q.push_back(sum);
      end
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result_value %08h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        report($sformatf("result_value %08h, expected %08h", got, want));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [0:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] a_even_i;
  logic [15:0] a_odd_i;
  logic [15:0] b_even_i;
  logic [15:0] b_odd_i;
  logic        first_i;
  logic        last_i;
  logic [31:0] prior_sum_i;
  logic [31:0] bias_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] result_value_o;

  dot_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            quiet_cycles;

  bf16_dot_product_accumulator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .a_even_i       (a_even_i),
    .a_odd_i        (a_odd_i),
    .b_even_i       (b_even_i),
    .b_odd_i        (b_odd_i),
    .first_i        (first_i),
    .last_i         (last_i),
    .prior_sum_i    (prior_sum_i),
    .bias_i         (bias_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check accepted results and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(result_value_o);
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ACC_MODE: sb.acc_mode = val;
      CFG_BIAS_EN:  sb.bias_en  = val;
      CFG_OUT_BF16: sb.out_bf16 = val;
      default: ;
    endcase
  endtask

  task automatic set_all_cfg(logic acc, logic bias_on, logic bf16_out);
    write_cfg(CFG_ACC_MODE, acc);
    @(posedge clk_i);
    write_cfg(CFG_BIAS_EN, bias_on);
    @(posedge clk_i);
    write_cfg(CFG_OUT_BF16, bf16_out);
    @(posedge clk_i);
  endtask

  // Wait until every expected result is back and the pipeline has emptied.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Present one item after idle cycles drawn one by one, and wait for acceptance.
  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    a_even_i    <= it.a_even;
    a_odd_i     <= it.a_odd;
    b_even_i    <= it.b_even;
    b_odd_i     <= it.b_odd;
    first_i     <= it.first;
    last_i      <= it.last;
    prior_sum_i <= it.prior_sum;
    bias_i      <= it.bias;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  function automatic item_t mk(logic [15:0] ae, logic [15:0] be, logic [15:0] ao,
                               logic [15:0] bo, logic f, logic l,
                               logic [31:0] ps, logic [31:0] bs);
    item_t it;
    it.a_even = ae;
    it.b_even = be;
    it.a_odd  = ao;
    it.b_odd  = bo;
    it.first  = f;
    it.last   = l;
    it.prior_sum = ps;
    it.bias   = bs;
    return it;
  endfunction

  // Mostly moderate magnitudes so sums stay meaningful, plus specials and raw bits.
  function automatic logic [15:0] rand_bf16();
    logic [15:0] specials[8] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80,
                                 16'h7FC1, 16'h0001, 16'h7F7F, 16'h0080};
    case ($urandom_range(0, 9))
      0:       return specials[$urandom_range(0, 7)];
      1, 2:    return 16'($urandom);
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 7'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_f32();
    logic [31:0] specials[6] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                 32'hFF80_0000, 32'h7F80_1234, 32'h7F7F_FFFF};
    case ($urandom_range(0, 9))
      0:       return specials[$urandom_range(0, 5)];
      1, 2:    return $urandom;
      default: return {1'($urandom), 8'($urandom_range(115, 140)), 23'($urandom)};
    endcase
  endfunction

  function automatic item_t rand_item(logic f, logic l);
    return mk(rand_bf16(), rand_bf16(), rand_bf16(), rand_bf16(), f, l,
              rand_f32(), rand_f32());
  endfunction

  // Mostly well-formed runs from first to last, with some stray flag patterns.
  task automatic send_random(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) send_item(rand_item(j == 0, j == len - 1));
        sent += len;
      end else begin
        send_item(rand_item(1'($urandom), 1'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ACC_MODE;
    cfg_wdata_i   = 1'b0;
    in_valid_i    = 1'b0;
    out_stall_i   = 1'b0;
    a_even_i      = 16'd0;
    a_odd_i       = 16'd0;
    b_even_i      = 16'd0;
    b_odd_i       = 16'd0;
    first_i       = 1'b0;
    last_i        = 1'b0;
    prior_sum_i   = 32'd0;
    bias_i        = 32'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with every option on.
    set_all_cfg(1'b1, 1'b1, 1'b1);
    // No first after reset: accumulation goes on from +0.0.
    send_item(mk(16'h3F80, 16'h4000, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0, 32'h0));
    send_item(mk(16'h3F80, 16'h3F80, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'h0, 32'h3F80_0000));
    // A NaN prior sum is loaded and turned into the quiet NaN by the first add.
    send_item(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 32'h7FC1_2345, 32'h0));
    // Largest finite sum rounds up to infinity in bf16.
    send_item(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 32'h7F7F_FFFF, 32'h0));
    // Infinity times zero, and overflow of the largest values.
    send_item(mk(16'h7F80, 16'h0000, 16'h3F80, 16'h3F80, 1'b1, 1'b1, 32'h0, 32'h0));
    send_item(mk(16'h7F7F, 16'h7F7F, 16'hFF7F, 16'h7F7F, 1'b1, 1'b1, 32'h0, 32'h0));
    // Underflow to zero and subnormal products.
    send_item(mk(16'h0001, 16'h0001, 16'h0080, 16'h3F00, 1'b1, 1'b1, 32'h0, 32'h0));
    send_item(mk(16'h0080, 16'h3E80, 16'h8001, 16'h3F80, 1'b1, 1'b1, 32'h0000_0001, 32'h0));
    // All bits set in every field.
    send_item(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Negative zeros stay negative.
    send_item(mk(16'h8000, 16'h3F80, 16'h8000, 16'h0000, 1'b1, 1'b1,
                 32'h8000_0000, 32'h8000_0000));
    // Infinite bias against an opposite infinite sum.
    send_item(mk(16'hFF80, 16'h3F80, 16'h0000, 16'h0000, 1'b1, 1'b1, 32'h0, 32'h7F80_0000));
    // Exact cancellation; the bias does not stay in the accumulator.
    send_item(mk(16'h3F80, 16'h3F80, 16'hBF80, 16'h3F80, 1'b1, 1'b1, 32'h0, 32'h4120_0000));
    send_item(mk(16'h4040, 16'h4040, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'h0, 32'h0));
    drain();
    set_all_cfg(1'b0, 1'b0, 1'b0);
    send_item(mk(16'h3FC0, 16'h4049, 16'hC000, 16'h3F81, 1'b1, 1'b0, 32'h4000_0000, 32'h0));
    send_item(mk(16'h3F80, 16'h3F80, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'h0, 32'h4000_0000));

    // Random phases across every setting and idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      set_all_cfg(ph[0], ph[1], ph[2]);
      if (ph < 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 81;
      end else if (ph < 6) begin
        send_idle_pct = 81;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random(ITEMS_PER_PHASE);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
